// ===== rtl/core/xrpc_pkg.sv =====
// Shared types and constants of the XOR range pair counter.
`timescale 1ns / 1ps

package xrpc_pkg;

    localparam int DEF_ENTRIES    = 1024;
    localparam int DEF_VALUE_BITS = 32;

    localparam int IN_VALUE_W = 32;
    localparam int CFG_W      = 32;
    localparam int PAIRS_W    = 11;
    localparam int TOTAL_W    = 19;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'd1;

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic                  first;
    } t_in;

    typedef struct packed {
        logic [PAIRS_W-1:0] pairs_with_item;
        logic [TOTAL_W-1:0] total_pairs;
        logic               store_full;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WALK,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/core/xrpc_cell.sv =====
// One trie level: node memory, allocation counter, query and insert step.
`timescale 1ns / 1ps

module xrpc_cell #(
    parameter int ENTRIES    = xrpc_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = xrpc_pkg::DEF_VALUE_BITS,
    parameter int LEVEL      = 0,
    localparam int NW        = $clog2(ENTRIES + 1),
    localparam int HW        = 6 + 7 * NW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic [VALUE_BITS-1:0] i_num,
    input  logic [VALUE_BITS-1:0] i_bhi,
    input  logic [VALUE_BITS-1:0] i_blo,
    input  logic [HW-1:0]         i_hand,
    input  logic [HW-1:0]         i_hand_next,
    output logic [HW-1:0]         o_hand,
    output logic [HW-1:0]         o_hand_next
);
    import xrpc_pkg::*;

    localparam int BIT   = VALUE_BITS - 1 - LEVEL;
    localparam int DEPTH = ENTRIES + 1;
    localparam int EW    = 4 * NW;

    typedef struct packed {
        logic          vld;
        logic          qz;
        logic          hi_alive;
        logic [NW-1:0] hi_node;
        logic [NW-1:0] hi_acc;
        logic [NW-1:0] hi_carry;
        logic          lo_alive;
        logic [NW-1:0] lo_node;
        logic [NW-1:0] lo_acc;
        logic [NW-1:0] lo_carry;
        logic          ins_en;
        logic          ins_fresh;
        logic [NW-1:0] ins_node;
    } t_hand;

    // entry: {cnt1, cnt0, link1, link0}; link 0 means no child
    logic [EW-1:0] r_mem_a [0:DEPTH-1];
    logic [EW-1:0] r_mem_b [0:DEPTH-1];
    logic [EW-1:0] r_rd_ins;
    logic [EW-1:0] r_rd_hi;
    logic [EW-1:0] r_rd_lo;
    logic [NW-1:0] r_next;
    t_hand         r_out;
    t_hand         n_out;
    t_hand         w_in;
    t_hand         w_pre;
    logic [EW-1:0] w_e_ins;
    logic [EW-1:0] w_e_hi;
    logic [EW-1:0] w_e_lo;
    logic [EW-1:0] w_wr;
    logic [NW-1:0] w_lk;
    logic [NW-1:0] w_ck;
    logic [NW-1:0] w_new_link;
    logic [NW-1:0] w_new_cnt;
    logic          w_alloc;
    logic          w_b;
    logic [3*NW:0] w_qhi;
    logic [3*NW:0] w_qlo;

    // result: {alive, node, acc, carry}
    function automatic logic [3*NW:0] q_step(
        input logic          alive,
        input logic [NW-1:0] node,
        input logic [NW-1:0] acc,
        input logic [NW-1:0] carry,
        input logic [EW-1:0] e,
        input logic          nb,
        input logic          bb
    );
        logic [NW-1:0] same_l;
        logic [NW-1:0] same_c;
        logic [NW-1:0] oth_l;
        logic [NW-1:0] oth_c;
        logic [3*NW:0] res;
        same_l = nb ? e[2*NW-1:NW]   : e[NW-1:0];
        oth_l  = nb ? e[NW-1:0]      : e[2*NW-1:NW];
        same_c = nb ? e[4*NW-1:3*NW] : e[3*NW-1:2*NW];
        oth_c  = nb ? e[3*NW-1:2*NW] : e[4*NW-1:3*NW];
        res    = {alive, node, acc, carry};
        if (alive) begin
            if (bb) begin
                // whole same-side subtree lies below the bound
                res = {(oth_l != '0), oth_l, acc + same_c, oth_c};
            end else begin
                res = {(same_l != '0), same_l, acc, same_c};
            end
        end
        return res;
    endfunction

    assign w_in  = t_hand'(i_hand);
    assign w_pre = t_hand'(i_hand_next);

    always_ff @(posedge i_clk) begin
        r_rd_ins <= r_mem_a[w_pre.ins_node];
        r_rd_hi  <= r_mem_a[w_pre.hi_node];
        r_rd_lo  <= r_mem_b[w_pre.lo_node];
        if (w_in.vld && w_in.ins_en) begin
            r_mem_a[w_in.ins_node] <= w_wr;
            r_mem_b[w_in.ins_node] <= w_wr;
        end
    end

    always_comb begin
        w_e_ins = w_in.ins_fresh ? '0 : r_rd_ins;
        w_e_hi  = w_in.qz ? '0 : r_rd_hi;
        w_e_lo  = w_in.qz ? '0 : r_rd_lo;
        w_b     = i_num[BIT];
        w_lk    = w_b ? w_e_ins[2*NW-1:NW]   : w_e_ins[NW-1:0];
        w_ck    = w_b ? w_e_ins[4*NW-1:3*NW] : w_e_ins[3*NW-1:2*NW];
        w_alloc = w_in.vld && w_in.ins_en && (w_lk == '0);
        w_new_link = w_alloc ? r_next : w_lk;
        w_new_cnt  = w_ck + NW'(1);
        w_wr = w_e_ins;
        if (w_b) begin
            w_wr[2*NW-1:NW]   = w_new_link;
            w_wr[4*NW-1:3*NW] = w_new_cnt;
        end else begin
            w_wr[NW-1:0]      = w_new_link;
            w_wr[3*NW-1:2*NW] = w_new_cnt;
        end
        w_qhi = q_step(w_in.hi_alive, w_in.hi_node, w_in.hi_acc, w_in.hi_carry,
                       w_e_hi, i_num[BIT], i_bhi[BIT]);
        w_qlo = q_step(w_in.lo_alive, w_in.lo_node, w_in.lo_acc, w_in.lo_carry,
                       w_e_lo, i_num[BIT], i_blo[BIT]);
        n_out           = w_in;
        n_out.qz        = 1'b0;
        n_out.hi_alive  = w_qhi[3*NW];
        n_out.hi_node   = w_qhi[3*NW-1:2*NW];
        n_out.hi_acc    = w_qhi[2*NW-1:NW];
        n_out.hi_carry  = w_qhi[NW-1:0];
        n_out.lo_alive  = w_qlo[3*NW];
        n_out.lo_node   = w_qlo[3*NW-1:2*NW];
        n_out.lo_acc    = w_qlo[2*NW-1:NW];
        n_out.lo_carry  = w_qlo[NW-1:0];
        n_out.ins_fresh = w_alloc;
        n_out.ins_node  = w_new_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next    <= NW'(1);
            r_out.vld <= 1'b0;
        end else begin
            if (i_clear) begin
                r_next <= NW'(1);
            end else if (w_alloc) begin
                r_next <= r_next + NW'(1);
            end
            r_out.vld <= w_in.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.qz        <= n_out.qz;
        r_out.hi_alive  <= n_out.hi_alive;
        r_out.hi_node   <= n_out.hi_node;
        r_out.hi_acc    <= n_out.hi_acc;
        r_out.hi_carry  <= n_out.hi_carry;
        r_out.lo_alive  <= n_out.lo_alive;
        r_out.lo_node   <= n_out.lo_node;
        r_out.lo_acc    <= n_out.lo_acc;
        r_out.lo_carry  <= n_out.lo_carry;
        r_out.ins_en    <= n_out.ins_en;
        r_out.ins_fresh <= n_out.ins_fresh;
        r_out.ins_node  <= n_out.ins_node;
    end

    assign o_hand      = HW'(r_out);
    assign o_hand_next = HW'(n_out);

endmodule

// ===== rtl/core/xor_range_pair_counter.sv =====
// Top level of the XOR range pair counter: control, bounds, chain of trie levels.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_stall    i_in  (value, first)
// output   out        o_valid / i_stall    o_out (pairs_with_item, total_pairs, store_full)
// config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Each item goes through accept, launch, the walk down the cell chain (one cell per
// trie level), the count capture, then the result load.
// Reset is synchronous, active low; the trie empties logically (root counts zero).
// o_stall is high while an item is in work; the result register lets the next item
// in while the previous result still waits on i_stall.
module xor_range_pair_counter #(
    parameter int ENTRIES    = xrpc_pkg::DEF_ENTRIES,
    parameter int VALUE_BITS = xrpc_pkg::DEF_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  xrpc_pkg::t_in                       i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output xrpc_pkg::t_out                      o_out,
    input  logic                                i_cfg_we,
    input  logic [xrpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [xrpc_pkg::CFG_W-1:0]          i_cfg_data
);
    import xrpc_pkg::*;

    localparam int NW = $clog2(ENTRIES + 1);
    localparam int HW = 6 + 7 * NW;
    localparam logic [CFG_W:0] VMASK = ((CFG_W+1)'(1) << VALUE_BITS) - (CFG_W+1)'(1);

    // same layout as the cell handoff
    typedef struct packed {
        logic          vld;
        logic          qz;
        logic          hi_alive;
        logic [NW-1:0] hi_node;
        logic [NW-1:0] hi_acc;
        logic [NW-1:0] hi_carry;
        logic          lo_alive;
        logic [NW-1:0] lo_node;
        logic [NW-1:0] lo_acc;
        logic [NW-1:0] lo_carry;
        logic          ins_en;
        logic          ins_fresh;
        logic [NW-1:0] ins_node;
    } t_hand;

    t_state                r_state;
    t_state                n_state;
    logic [CFG_W-1:0]      r_range_low;
    logic [CFG_W-1:0]      r_range_high;
    logic [VALUE_BITS-1:0] r_num;
    logic [VALUE_BITS-1:0] r_bhi;
    logic [VALUE_BITS-1:0] r_blo;
    logic [NW-1:0]         r_items;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_full;
    logic [NW-1:0]         r_pairs;
    logic                  r_ovalid;
    t_out                  r_out;
    t_hand                 r_head;
    t_hand                 n_head;
    t_hand                 w_tail;

    logic                  w_accept;
    logic                  w_launch;
    logic                  w_capture;
    logic                  w_fin_go;
    logic                  w_out_free;
    logic                  w_ok;
    logic                  w_lo_use;
    logic                  w_hi_all;
    logic                  w_lo_all;
    logic                  w_full;
    logic [CFG_W-1:0]      w_blo;
    logic [NW-1:0]         w_hi_cnt;
    logic [NW-1:0]         w_lo_cnt;
    logic [TOTAL_W:0]      w_sum;
    logic [TOTAL_W-1:0]    w_total;

    logic [HW-1:0]         w_hand      [0:VALUE_BITS];
    logic [HW-1:0]         w_hand_next [0:VALUE_BITS];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_ovalid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_WALK;
            ST_WALK:   if (w_tail.vld) n_state = ST_FIN;
            ST_FIN:    if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall   = 1'b1;
        w_accept  = 1'b0;
        w_launch  = 1'b0;
        w_capture = 1'b0;
        w_fin_go  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall  = 1'b0;
                w_accept = i_valid;
            end
            ST_LAUNCH: w_launch  = 1'b1;
            ST_WALK:   w_capture = w_tail.vld;
            ST_FIN:    w_fin_go  = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // bounds; a bound at or above the value mask takes every held value
    assign w_ok     = r_range_low <= r_range_high;
    assign w_lo_use = w_ok && (r_range_low != '0);
    assign w_blo    = r_range_low - CFG_W'(1);
    assign w_hi_all = {1'b0, r_range_high} >= VMASK;
    assign w_lo_all = {1'b0, w_blo} >= VMASK;
    assign w_full   = r_items >= NW'(ENTRIES);

    always_comb begin
        n_head.vld       = w_launch;
        n_head.qz        = (r_items == '0);
        n_head.hi_alive  = w_ok && !w_hi_all;
        n_head.hi_node   = NW'(1);
        n_head.hi_acc    = (w_ok && w_hi_all) ? r_items : '0;
        n_head.hi_carry  = '0;
        n_head.lo_alive  = w_lo_use && !w_lo_all;
        n_head.lo_node   = NW'(1);
        n_head.lo_acc    = (w_lo_use && w_lo_all) ? r_items : '0;
        n_head.lo_carry  = '0;
        n_head.ins_en    = !w_full;
        n_head.ins_fresh = (r_items == '0);
        n_head.ins_node  = NW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else begin
            r_head.vld <= w_launch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head.qz        <= n_head.qz;
        r_head.hi_alive  <= n_head.hi_alive;
        r_head.hi_node   <= n_head.hi_node;
        r_head.hi_acc    <= n_head.hi_acc;
        r_head.hi_carry  <= n_head.hi_carry;
        r_head.lo_alive  <= n_head.lo_alive;
        r_head.lo_node   <= n_head.lo_node;
        r_head.lo_acc    <= n_head.lo_acc;
        r_head.lo_carry  <= n_head.lo_carry;
        r_head.ins_en    <= n_head.ins_en;
        r_head.ins_fresh <= n_head.ins_fresh;
        r_head.ins_node  <= n_head.ins_node;
        if (w_accept) begin
            r_num <= i_in.value[VALUE_BITS-1:0];
        end
        if (w_launch) begin
            r_bhi  <= r_range_high[VALUE_BITS-1:0];
            r_blo  <= w_blo[VALUE_BITS-1:0];
            r_full <= w_full;
        end
        if (w_capture) begin
            r_pairs <= w_hi_cnt - w_lo_cnt;
        end
    end

    assign w_hand[0]      = HW'(r_head);
    assign w_hand_next[0] = HW'(n_head);

    // one cell per trie level, most significant bit first
    for (genvar l = 0; l < VALUE_BITS; l++) begin : g_level
        xrpc_cell #(
            .ENTRIES    (ENTRIES),
            .VALUE_BITS (VALUE_BITS),
            .LEVEL      (l)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (w_accept && i_in.first),
            .i_num       (r_num),
            .i_bhi       (r_bhi),
            .i_blo       (r_blo),
            .i_hand      (w_hand[l]),
            .i_hand_next (w_hand_next[l]),
            .o_hand      (w_hand[l+1]),
            .o_hand_next (w_hand_next[l+1])
        );
    end

    assign w_tail   = t_hand'(w_hand[VALUE_BITS]);
    // leaf count carried out of the last level closes each walk
    assign w_hi_cnt = w_tail.hi_acc + w_tail.hi_carry;
    assign w_lo_cnt = w_tail.lo_acc + w_tail.lo_carry;

    assign w_sum   = {1'b0, r_total} + (TOTAL_W+1)'(r_pairs);
    assign w_total = (w_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : w_sum[TOTAL_W-1:0];

    // running state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept && i_in.first) begin
                r_items <= '0;
                r_total <= '0;
            end else if (w_fin_go) begin
                r_total <= w_total;
                if (!r_full) begin
                    r_items <= r_items + NW'(1);
                end
            end
            if (w_fin_go) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out.pairs_with_item <= PAIRS_W'(r_pairs);
            r_out.total_pairs     <= w_total;
            r_out.store_full      <= r_full;
        end
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

endmodule
